### rtl/core/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

### rtl/core/apc_pkg.sv
// Shared types and constants for the amicable pair check unit.
package apc_pkg;
    localparam int NUMBER_WIDTH = 32;
    localparam int SUM_OUT_W    = 35;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_DIV,
        LN_EVAL,
        LN_DONE
    } t_lane_state;
endpackage

### rtl/core/apc_lane.sv
// One lane: aliquot sum of a number by trial division with a bit-serial divider.
module apc_lane #(
    parameter int W = apc_pkg::NUMBER_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_number,
    output logic           o_done,
    output logic [W+2:0]   o_sum
);
    localparam int DW    = (W + 1) / 2 + 1;
    localparam int CW    = $clog2(W);
    localparam int SUM_W = W + 3;

    apc_pkg::t_lane_state r_state, n_state;
    logic [W-1:0]     r_num, n_num;
    logic [W-1:0]     r_shift, n_shift;
    logic [W-1:0]     r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_d, n_d;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;

    // One restoring division step
    logic [DW:0] rem_sh;
    logic        ge;
    logic [DW:0] rem_sub;
    always_comb begin
        rem_sh  = {r_rem, r_shift[W-1]};
        ge      = (rem_sh >= {1'b0, r_d});
        rem_sub = rem_sh - {1'b0, r_d};
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apc_pkg::LN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_shift <= n_shift;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        r_sum   <= n_sum;
    end

    // Next state: divide n by d, then test d against the quotient
    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_shift = r_shift;
        n_q     = r_q;
        n_rem   = r_rem;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        case (r_state)
            apc_pkg::LN_DIV: begin
                n_shift = {r_shift[W-2:0], 1'b0};
                n_q     = {r_q[W-2:0], ge};
                n_rem   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_state = apc_pkg::LN_EVAL;
                end
            end
            apc_pkg::LN_EVAL: begin
                if (W'(r_d) > r_q) begin
                    n_state = apc_pkg::LN_DONE;
                end else begin
                    if (r_rem == '0) begin
                        n_sum = r_sum + SUM_W'(r_d)
                              + ((r_q != W'(r_d)) ? SUM_W'(r_q) : '0);
                    end
                    n_d     = r_d + DW'(1);
                    n_shift = r_num;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = apc_pkg::LN_DIV;
                end
            end
            default: ;
        endcase
        // A new transaction overrides whatever the lane holds
        if (i_start) begin
            n_num   = i_number;
            n_shift = i_number;
            n_rem   = '0;
            n_cnt   = '0;
            n_d     = DW'(2);
            if (i_number < W'(2)) begin
                n_sum   = '0;
                n_state = apc_pkg::LN_DONE;
            end else begin
                n_sum   = SUM_W'(1);
                n_state = apc_pkg::LN_DIV;
            end
        end
    end

    assign o_done = (r_state == apc_pkg::LN_DONE);
    assign o_sum  = r_sum;
endmodule

### rtl/core/apc_merge.sv
// Merge stage: waits for both lanes, compares the sums and registers the result.
module apc_merge #(
    parameter int W = apc_pkg::NUMBER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [W-1:0]                   i_first_number,
    input  logic [W-1:0]                   i_second_number,
    input  logic                           i_first_done,
    input  logic                           i_second_done,
    input  logic [W+2:0]                   i_first_sum,
    input  logic [W+2:0]                   i_second_sum,
    output logic                           o_wait,
    output logic                           o_done,
    output logic [apc_pkg::SUM_OUT_W-1:0]  o_first_divisor_sum,
    output logic [apc_pkg::SUM_OUT_W-1:0]  o_second_divisor_sum,
    output logic                           o_is_amicable
);
    localparam int SUM_W = W + 3;
    localparam int EXT_W = (SUM_W > apc_pkg::SUM_OUT_W) ? SUM_W : apc_pkg::SUM_OUT_W;

    logic                          r_wait, n_wait;
    logic                          r_done, n_done;
    logic [W-1:0]                  r_a, r_b;
    logic [apc_pkg::SUM_OUT_W-1:0] r_sa, r_sb;
    logic                          r_match;
    logic                          fire, match;
    logic [EXT_W-1:0]              sa_ext, sb_ext;

    // Full-width compare against the other number
    always_comb begin
        fire   = r_wait && i_first_done && i_second_done;
        match  = (r_a != '0) && (r_b != '0)
              && (i_first_sum == SUM_W'(r_b)) && (i_second_sum == SUM_W'(r_a));
        sa_ext = EXT_W'(i_first_sum);
        sb_ext = EXT_W'(i_second_sum);
        n_wait = i_start ? 1'b1 : (fire ? 1'b0 : r_wait);
        n_done = fire;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_wait <= n_wait;
            r_done <= n_done;
        end
    end

    // Operands and result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_first_number;
            r_b <= i_second_number;
        end
        if (fire) begin
            r_sa    <= sa_ext[apc_pkg::SUM_OUT_W-1:0];
            r_sb    <= sb_ext[apc_pkg::SUM_OUT_W-1:0];
            r_match <= match;
        end
    end

    assign o_wait               = r_wait;
    assign o_done               = r_done;
    assign o_first_divisor_sum  = r_sa;
    assign o_second_divisor_sum = r_sb;
    assign o_is_amicable        = r_match;
endmodule

### rtl/core/amicable_pair_check_unit.sv
// Amicable pair check: two aliquot-sum lanes and a merge stage.
// A transaction starts when i_start is high while o_busy is low. Each number
// runs in its own lane, trial division by d = 2, 3, ... until d exceeds n/d,
// and each division is a restoring divider followed by a check of the
// quotient, so a number n >= 2 tests floor(sqrt(n)) divisors; 0 and 1 go
// straight to done. The merge stage waits for the slower lane of the pair and
// registers the result. The result is shown for one cycle with o_done high and
// cannot be stalled; o_busy drops in that same cycle, so the next transaction
// may start right away.
`include "assert_macros.svh"
module amicable_pair_check_unit #(
    parameter int NUMBER_WIDTH = apc_pkg::NUMBER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NUMBER_WIDTH-1:0]        i_first_number,
    input  logic [NUMBER_WIDTH-1:0]        i_second_number,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [apc_pkg::SUM_OUT_W-1:0]  o_first_divisor_sum,
    output logic [apc_pkg::SUM_OUT_W-1:0]  o_second_divisor_sum,
    output logic                           o_is_amicable
);
    logic                    accept;
    logic                    first_done, second_done;
    logic [NUMBER_WIDTH+2:0] first_sum, second_sum;

    assign accept = i_start && !o_busy;

    // Lanes
    apc_lane #(.W(NUMBER_WIDTH)) u_lane_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_number (i_first_number),
        .o_done   (first_done),
        .o_sum    (first_sum)
    );

    apc_lane #(.W(NUMBER_WIDTH)) u_lane_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_number (i_second_number),
        .o_done   (second_done),
        .o_sum    (second_sum)
    );

    // Merge
    apc_merge #(.W(NUMBER_WIDTH)) u_merge (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (accept),
        .i_first_number       (i_first_number),
        .i_second_number      (i_second_number),
        .i_first_done         (first_done),
        .i_second_done        (second_done),
        .i_first_sum          (first_sum),
        .i_second_sum         (second_sum),
        .o_wait               (o_busy),
        .o_done               (o_done),
        .o_first_divisor_sum  (o_first_divisor_sum),
        .o_second_divisor_sum (o_second_divisor_sum),
        .o_is_amicable        (o_is_amicable)
    );

    // Checks
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy, "accepted transaction not busy")
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `ASSERT_IMPLIES(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "result while still busy")
endmodule

### bench/tb_amicable_pair_check_unit.sv
// Testbench for the amicable pair check unit: directed and random pairs checked by a scoreboard.
`timescale 1ns / 1ps

module tb_amicable_pair_check_unit;
    localparam int W = apc_pkg::NUMBER_WIDTH;

    typedef struct {
        logic [apc_pkg::SUM_OUT_W-1:0] first_sum;
        logic [apc_pkg::SUM_OUT_W-1:0] second_sum;
        logic                          amicable;
    } t_pair_result;

    // Scoreboard: predicts each pair's sums and checks results in order
    class pair_scoreboard;
        t_pair_result pending[$];
        int           errors;

        // Sum of proper divisors, kept wide so the match test sees every bit
        function longint unsigned divisor_sum(logic [W-1:0] n);
            longint unsigned total;
            longint unsigned d;
            longint unsigned val;
            val = n;
            if (val < 2)
                return 0;
            total = 1;
            for (d = 2; d <= val / d; d++) begin
                if (val % d == 0) begin
                    total += d;
                    if (val / d != d)
                        total += val / d;
                end
            end
            return total;
        endfunction

        function void note_pair(logic [W-1:0] a, logic [W-1:0] b);
            longint unsigned sa;
            longint unsigned sb;
            t_pair_result    r;
            sa = divisor_sum(a);
            sb = divisor_sum(b);
            r.first_sum  = sa[apc_pkg::SUM_OUT_W-1:0];
            r.second_sum = sb[apc_pkg::SUM_OUT_W-1:0];
            r.amicable   = (a != 0) && (b != 0) && (sa == b) && (sb == a);
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_pair_result got);
            t_pair_result exp_r;
            if (pending.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            exp_r = pending.pop_front();
            if (got.first_sum !== exp_r.first_sum)
                report($sformatf("first sum %0d, want %0d", got.first_sum, exp_r.first_sum));
            if (got.second_sum !== exp_r.second_sum)
                report($sformatf("second sum %0d, want %0d",
                                 got.second_sum, exp_r.second_sum));
            if (got.amicable !== exp_r.amicable)
                report($sformatf("amicable flag %0b, want %0b", got.amicable, exp_r.amicable));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic [W-1:0]                  i_first_number = '0;
    logic [W-1:0]                  i_second_number = '0;
    logic                          o_busy;
    logic                          o_done;
    logic [apc_pkg::SUM_OUT_W-1:0] o_first_divisor_sum;
    logic [apc_pkg::SUM_OUT_W-1:0] o_second_divisor_sum;
    logic                          o_is_amicable;

    pair_scoreboard sb = new();
    int             idle_pct;

    amicable_pair_check_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .i_first_number       (i_first_number),
        .i_second_number      (i_second_number),
        .o_busy               (o_busy),
        .o_done               (o_done),
        .o_first_divisor_sum  (o_first_divisor_sum),
        .o_second_divisor_sum (o_second_divisor_sum),
        .o_is_amicable        (o_is_amicable)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_pair_result got;
        if (i_rst_n && o_done) begin
            got.first_sum  = o_first_divisor_sum;
            got.second_sum = o_second_divisor_sum;
            got.amicable   = o_is_amicable;
            sb.check_result(got);
        end
    end

    // Issue one pair; optional idle cycles first, start held until accepted
    task send_pair(logic [W-1:0] a, logic [W-1:0] b);
        logic busy_seen;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start         = 1'b1;
        i_first_number  = a;
        i_second_number = b;
        forever begin
            busy_seen = o_busy;
            @(posedge i_clk);
            if (!busy_seen)
                break;
            @(negedge i_clk);
        end
        sb.note_pair(a, b);
    endtask

    task release_start();
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // Random number, mostly 16 bits or fewer to keep trial division short
    function logic [W-1:0] rand_num();
        int bits;
        bits = ($urandom_range(19) == 0) ? 20 : $urandom_range(16);
        if (bits == 0)
            return $urandom_range(1);
        return $urandom & ((32'h1 << bits) - 1);
    endfunction

    logic [W-1:0] amic_a[8] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
    logic [W-1:0] amic_b[8] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
    logic [W-1:0] perfect[4] = '{6, 28, 496, 8128};

    initial begin
        int k;
        int sel;
        logic [W-1:0] a;
        logic [W-1:0] b;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, one, primes, squares, pairs, perfect numbers, all ones
        idle_pct = 0;
        send_pair(0, 0);
        send_pair(0, 284);
        send_pair(220, 0);
        send_pair(1, 1);
        send_pair(1, 0);
        send_pair(2, 3);
        send_pair(4, 9);
        send_pair(36, 49);
        send_pair(220, 284);
        send_pair(284, 220);
        send_pair(1184, 1210);
        send_pair(220, 285);
        send_pair(6, 6);
        send_pair(28, 28);
        send_pair(496, 8128);
        send_pair(65521, 65536);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'h0001_0000, 32'h0000_FFFF);

        // Random phases: sender idles 16%, then 62%, then never
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 16 : (ph == 1) ? 62 : 0;
            for (k = 0; k < 28; k++) begin
                sel = $urandom_range(9);
                if (sel < 3) begin
                    sel = $urandom_range(7);
                    if ($urandom_range(1)) begin
                        a = amic_a[sel];
                        b = amic_b[sel];
                    end else begin
                        a = amic_b[sel];
                        b = amic_a[sel];
                    end
                end else if (sel == 3) begin
                    a = perfect[$urandom_range(3)];
                    b = ($urandom_range(1)) ? a : perfect[$urandom_range(3)];
                end else begin
                    a = rand_num();
                    b = rand_num();
                end
                send_pair(a, b);
                if ($urandom_range(3) == 0)
                    release_start();
            end
        end
        release_start();

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("amicable_pair_check_unit: match");
        else
            $display("amicable_pair_check_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #300_000_000;
        $display("amicable_pair_check_unit: mismatch");
        $finish;
    end
endmodule
